### src/pmbh_pkg.sv
package pmbh_pkg;

  // strip table
  localparam int STRIPS_DEFAULT = 16;
  localparam int STRIP_SEL_W    = 7;   // holds any strip count up to 127

  // field widths
  localparam int STRIP_W  = 4;
  localparam int PEAK_W   = 16;
  localparam int VOL_W    = 8;
  localparam int PX_W     = 8;
  localparam int AGE_W    = 8;
  localparam int FACTOR_W = 16;

  // configuration port
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_METER_HEIGHT = 2'd0,
    CFG_FALL         = 2'd1,
    CFG_HOLD_FALL    = 2'd2,
    CFG_HOLD_FRAMES  = 2'd3
  } cfg_addr_t;

  localparam logic [PX_W-1:0]     RST_METER_HEIGHT = 8'd80;
  localparam logic [FACTOR_W-1:0] RST_FALL         = 16'd52429;
  localparam logic [FACTOR_W-1:0] RST_HOLD_FALL    = 16'd62915;
  localparam logic [AGE_W-1:0]    RST_HOLD_FRAMES  = 8'd30;

  typedef struct packed {
    logic [PX_W-1:0]     height;
    logic [FACTOR_W-1:0] fall;
    logic [FACTOR_W-1:0] hold_fall;
    logic [AGE_W-1:0]    hold_frames;
  } cfg_t;

  // peak thresholds, U2.14
  localparam logic [PEAK_W-1:0] SNAP_BELOW = 16'd17;
  localparam logic [PEAK_W-1:0] BAR_MIN    = 16'd2;
  localparam logic [PEAK_W-1:0] HOLD_MIN   = 16'd164;
  localparam logic [PEAK_W-1:0] PEAK_CLAMP = 16'd32768;
  localparam logic [VOL_W-1:0]  VOL_MIN    = 8'd2;

  // log2 / dB / pixel mapping
  localparam int L2_W = 22;
  localparam int DB_W = 18;
  localparam logic signed [L2_W-1:0] L2_OFFSET_PEAK = 22'sd917504;  // 14 fraction bits
  localparam logic signed [L2_W-1:0] L2_OFFSET_VOL  = 22'sd435412;  // log2(100)
  localparam logic [15:0]            DB_COEF_Q12    = 16'd24660;
  localparam logic signed [DB_W:0]   DB_LOW_Q8      = 19'sd12288;
  localparam logic [13:0]            DB_SPAN_Q8     = 14'd13824;
  // 13824 = 512 * 27: shift by 9, then divide by 27 through a reciprocal
  localparam int                     PX_SHIFT       = 9;
  localparam logic [13:0]            RECIP_27       = 14'd9709;   // floor(2^18 / 27)
  localparam logic [4:0]             DIV_27         = 5'd27;
  localparam int                     CONV_DEPTH     = 6;

  localparam logic [16:0] LOG2_TAB [17] = '{
    17'd0,     17'd5732,  17'd11136, 17'd16248, 17'd21098, 17'd25711,
    17'd30109, 17'd34312, 17'd38336, 17'd42196, 17'd45904, 17'd49472,
    17'd52911, 17'd56229, 17'd59434, 17'd62534, 17'd65536
  };

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic bar_on;
    logic hold_on;
    logic vol_on;
  } show_t;

  typedef struct packed {
    logic [STRIP_W-1:0] strip;
    show_t              show;
    logic [PEAK_W-1:0]  sp;
    logic [PEAK_W-1:0]  hp;
    logic [VOL_W-1:0]   vol;
  } item_t;

endpackage

### src/pmbh_if.sv
interface pmbh_in_if;
  logic                            valid;
  logic                            ready;
  logic [pmbh_pkg::STRIP_W-1:0]    strip;
  logic [pmbh_pkg::PEAK_W-1:0]     live_peak;
  logic [pmbh_pkg::VOL_W-1:0]      volume_percent;

  modport source(output valid, strip, live_peak, volume_percent, input ready);
  modport sink(input valid, strip, live_peak, volume_percent, output ready);
endinterface

interface pmbh_out_if;
  logic                            valid;
  logic                            ready;
  logic [pmbh_pkg::STRIP_W-1:0]    strip_out;
  logic [pmbh_pkg::PX_W-1:0]       bar_px;
  logic [pmbh_pkg::PX_W-1:0]       hold_px;
  logic                            hold_visible;
  logic [pmbh_pkg::PX_W-1:0]       volume_px;
  logic                            volume_visible;

  modport source(output valid, strip_out, bar_px, hold_px, hold_visible, volume_px,
                 volume_visible, input ready);
  modport sink(input valid, strip_out, bar_px, hold_px, hold_visible, volume_px,
               volume_visible, output ready);
endinterface

### src/pmbh_front.sv
module pmbh_front #(
  parameter int STRIPS = pmbh_pkg::STRIPS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pmbh_pkg::cfg_t   cfg_i,
  pmbh_in_if.sink          in_ch,
  output logic             push_o,
  output pmbh_pkg::item_t  push_data_o,
  input  logic             full_i
);

  localparam int IDX_W = (STRIPS > 1) ? $clog2(STRIPS) : 1;

  typedef struct packed {
    logic [pmbh_pkg::PEAK_W-1:0] sp;
    logic [pmbh_pkg::PEAK_W-1:0] hp;
    logic [pmbh_pkg::AGE_W-1:0]  age;
  } entry_t;

  typedef enum logic {F_IDLE, F_UPDATE} state_t;

  state_t      state_r;
  entry_t      mem [STRIPS];
  logic [STRIPS-1:0] filled_r;
  entry_t      rd_r;
  logic        rd_filled_r;
  logic [pmbh_pkg::STRIP_W-1:0] strip_r;
  logic [pmbh_pkg::PEAK_W-1:0]  live_r;
  logic [pmbh_pkg::VOL_W-1:0]   vol_r;
  logic        in_range_r;
  logic [IDX_W-1:0] idx_r;

  logic [pmbh_pkg::STRIP_SEL_W-1:0] strip_ext;
  logic [IDX_W-1:0] idx;
  logic        in_range;
  logic        accept;
  logic        wr_en;

  entry_t      old_e;
  entry_t      new_e;
  logic [31:0] sp_prod;
  logic [31:0] hp_prod;
  logic [pmbh_pkg::PEAK_W-1:0] sp_dec;
  logic [pmbh_pkg::PEAK_W-1:0] hp_dec;
  logic [pmbh_pkg::AGE_W-1:0]  age_inc;
  logic [pmbh_pkg::PEAK_W-1:0] sp_clamped;

  assign strip_ext = pmbh_pkg::STRIP_SEL_W'(in_ch.strip);
  assign in_range  = strip_ext < pmbh_pkg::STRIP_SEL_W'(STRIPS);
  assign idx       = strip_ext[IDX_W-1:0];
  assign in_ch.ready = (state_r == F_IDLE);
  assign accept    = in_ch.valid && in_ch.ready;
  assign push_o    = (state_r == F_UPDATE) && !full_i;
  assign wr_en     = push_o && in_range_r;

  // never-written entries read as zero
  assign old_e = rd_filled_r ? rd_r : '0;

  always_comb begin
    sp_prod = {16'b0, old_e.sp} * {16'b0, cfg_i.fall};
    hp_prod = {16'b0, old_e.hp} * {16'b0, cfg_i.hold_fall};
    sp_dec  = (sp_prod[31:16] < pmbh_pkg::SNAP_BELOW) ? '0 : sp_prod[31:16];
    hp_dec  = (hp_prod[31:16] < pmbh_pkg::SNAP_BELOW) ? '0 : hp_prod[31:16];
    age_inc = (old_e.age == '1) ? old_e.age : old_e.age + 1'b1;

    new_e.sp = (live_r > old_e.sp) ? live_r : sp_dec;
    if (live_r > old_e.hp) begin
      new_e.hp  = live_r;
      new_e.age = '0;
    end else begin
      new_e.age = age_inc;
      new_e.hp  = (age_inc > cfg_i.hold_frames) ? hp_dec : old_e.hp;
    end

    sp_clamped = (new_e.sp > pmbh_pkg::PEAK_CLAMP) ? pmbh_pkg::PEAK_CLAMP : new_e.sp;

    push_data_o.strip        = strip_r;
    push_data_o.sp           = sp_clamped;
    push_data_o.hp           = new_e.hp;
    push_data_o.vol          = vol_r;
    push_data_o.show.bar_on  = in_range_r && (sp_clamped >= pmbh_pkg::BAR_MIN);
    push_data_o.show.hold_on = in_range_r && (new_e.hp >= pmbh_pkg::HOLD_MIN);
    push_data_o.show.vol_on  = in_range_r && (vol_r >= pmbh_pkg::VOL_MIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      filled_r <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (accept) state_r <= F_UPDATE;
        end
        F_UPDATE: begin
          if (push_o) state_r <= F_IDLE;
        end
      endcase
      if (wr_en) filled_r[idx_r] <= 1'b1;
    end
  end

  // state memory: registered read on accept, write-back on push for in-range strips
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_r        <= mem[idx];
      rd_filled_r <= filled_r[idx];
      strip_r     <= in_ch.strip;
      live_r      <= in_ch.live_peak;
      vol_r       <= in_ch.volume_percent;
      in_range_r  <= in_range;
      idx_r       <= idx;
    end
    if (wr_en) mem[idx_r] <= new_e;
  end

endmodule

### src/pmbh_fifo.sv
module pmbh_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_i,
  input  pmbh_pkg::item_t  push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output pmbh_pkg::item_t  pop_data_o,
  output logic             empty_o
);

  localparam int PTR_W = (pmbh_pkg::QUEUE_DEPTH > 1) ? $clog2(pmbh_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(pmbh_pkg::QUEUE_DEPTH + 1);

  pmbh_pkg::item_t   slot_r [pmbh_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full_o     = (count_r == CNT_W'(pmbh_pkg::QUEUE_DEPTH));
  assign empty_o    = (count_r == '0);
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = slot_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] nxt;
    nxt = (p == PTR_W'(pmbh_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    return nxt;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data_i;
  end

endmodule

### src/pmbh_conv.sv
module pmbh_conv (
  input  logic                               clk,
  input  logic                               en_i,
  input  logic [pmbh_pkg::PEAK_W-1:0]        x_i,
  input  logic signed [pmbh_pkg::L2_W-1:0]   offset_i,
  input  logic [pmbh_pkg::PX_W-1:0]          height_i,
  output logic [pmbh_pkg::PX_W-1:0]          px_o
);

  // s0: normalize
  logic [3:0]  msb;
  logic [15:0] norm;
  logic [3:0]  msb_r;
  logic [3:0]  tidx_r;
  logic [10:0] rem_r;
  logic signed [pmbh_pkg::L2_W-1:0] offset_r;

  // s1: table interpolation
  logic [16:0] lo;
  logic [16:0] hi;
  logic [16:0] diff;
  logic [23:0] interp_prod;
  logic [16:0] frac;
  logic signed [pmbh_pkg::L2_W-1:0] l2_nxt;
  logic signed [pmbh_pkg::L2_W-1:0] l2_r;

  // s2: dB
  logic signed [37:0] db_prod;
  logic signed [pmbh_pkg::DB_W-1:0] db_r;

  // s3: pixel scale
  logic signed [pmbh_pkg::DB_W:0] num_s;
  logic [13:0] num;
  logic [21:0] scale_nxt;
  logic [21:0] scale_r;

  // s4: divide by 27, reciprocal estimate
  logic [12:0] y;
  logic [26:0] q_prod;
  logic [12:0] y_r;
  logic [8:0]  q0_r;

  // s5: correction
  logic [12:0] q27;
  logic [12:0] rem27;
  logic [8:0]  q_fix;

  always_comb begin
    msb = '0;
    for (int i = 1; i < 16; i++) begin
      if (x_i[i]) msb = 4'(i);
    end
    norm = x_i << (4'd15 - msb);
  end

  always_comb begin
    lo          = pmbh_pkg::LOG2_TAB[tidx_r];
    hi          = pmbh_pkg::LOG2_TAB[{1'b0, tidx_r} + 5'd1];
    diff        = hi - lo;
    interp_prod = diff[12:0] * rem_r;
    frac        = lo + {4'b0, interp_prod[23:11]};
    l2_nxt      = $signed({2'b00, msb_r, 16'b0}) + $signed({5'b0, frac}) - offset_r;
  end

  assign db_prod = l2_r * $signed({1'b0, pmbh_pkg::DB_COEF_Q12[14:0]});

  always_comb begin
    num_s = $signed({db_r[pmbh_pkg::DB_W-1], db_r}) + pmbh_pkg::DB_LOW_Q8;
    if (num_s < 0) begin
      num = '0;
    end else if (num_s > $signed({5'b0, pmbh_pkg::DB_SPAN_Q8})) begin
      num = pmbh_pkg::DB_SPAN_Q8;
    end else begin
      num = num_s[13:0];
    end
    scale_nxt = {8'b0, num} * {14'b0, height_i};
  end

  assign y      = scale_r[21:pmbh_pkg::PX_SHIFT];
  assign q_prod = {14'b0, y} * {13'b0, pmbh_pkg::RECIP_27};

  always_comb begin
    q27   = 13'({4'b0, q0_r} * {8'b0, pmbh_pkg::DIV_27});
    rem27 = y_r - q27;
    q_fix = (rem27 >= {8'b0, pmbh_pkg::DIV_27}) ? q0_r + 1'b1 : q0_r;
  end

  always_ff @(posedge clk) begin
    if (en_i) begin
      msb_r    <= msb;
      tidx_r   <= norm[14:11];
      rem_r    <= norm[10:0];
      offset_r <= offset_i;
      l2_r     <= l2_nxt;
      db_r     <= db_prod[37:20];
      scale_r  <= scale_nxt;
      y_r      <= y;
      q0_r     <= q_prod[26:18];
      px_o     <= q_fix[pmbh_pkg::PX_W-1:0];
    end
  end

endmodule

### src/pmbh_back.sv
module pmbh_back (
  input  logic             clk,
  input  logic             rst_n,
  input  pmbh_pkg::cfg_t   cfg_i,
  input  pmbh_pkg::item_t  head_i,
  input  logic             empty_i,
  output logic             pop_o,
  pmbh_out_if.source       out_ch
);

  localparam int D = pmbh_pkg::CONV_DEPTH;

  logic                          en;
  logic [D-1:0]                  valid_r;
  pmbh_pkg::show_t               show_r  [D];
  logic [pmbh_pkg::STRIP_W-1:0]  strip_r [D];

  logic [pmbh_pkg::PX_W-1:0]     bar_raw;
  logic [pmbh_pkg::PX_W-1:0]     hold_raw;
  logic [pmbh_pkg::PX_W-1:0]     vol_raw;
  logic [pmbh_pkg::PX_W-1:0]     marker_top;

  logic                          out_valid_r;
  logic [pmbh_pkg::STRIP_W-1:0]  out_strip_r;
  logic [pmbh_pkg::PX_W-1:0]     out_bar_r;
  logic [pmbh_pkg::PX_W-1:0]     out_hold_r;
  logic                          out_hold_vis_r;
  logic [pmbh_pkg::PX_W-1:0]     out_vol_r;
  logic                          out_vol_vis_r;

  // whole pipeline advances together, held while the output waits
  assign en    = !out_valid_r || out_ch.ready;
  assign pop_o = en && !empty_i;

  pmbh_conv u_conv_bar (
    .clk      (clk),
    .en_i     (en),
    .x_i      (head_i.sp),
    .offset_i (pmbh_pkg::L2_OFFSET_PEAK),
    .height_i (cfg_i.height),
    .px_o     (bar_raw)
  );

  pmbh_conv u_conv_hold (
    .clk      (clk),
    .en_i     (en),
    .x_i      (head_i.hp),
    .offset_i (pmbh_pkg::L2_OFFSET_PEAK),
    .height_i (cfg_i.height),
    .px_o     (hold_raw)
  );

  pmbh_conv u_conv_vol (
    .clk      (clk),
    .en_i     (en),
    .x_i      (pmbh_pkg::PEAK_W'(head_i.vol)),
    .offset_i (pmbh_pkg::L2_OFFSET_VOL),
    .height_i (cfg_i.height),
    .px_o     (vol_raw)
  );

  assign marker_top = (cfg_i.height == '0) ? '0 : cfg_i.height - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      valid_r     <= {valid_r[D-2:0], pop_o};
      out_valid_r <= valid_r[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      show_r[0]  <= head_i.show;
      strip_r[0] <= head_i.strip;
      for (int i = 1; i < D; i++) begin
        show_r[i]  <= show_r[i-1];
        strip_r[i] <= strip_r[i-1];
      end
      out_strip_r    <= strip_r[D-1];
      out_bar_r      <= !show_r[D-1].bar_on ? '0 :
                        (bar_raw > cfg_i.height) ? cfg_i.height : bar_raw;
      out_hold_r     <= !show_r[D-1].hold_on ? '0 :
                        (hold_raw > marker_top) ? marker_top : hold_raw;
      out_hold_vis_r <= show_r[D-1].hold_on;
      out_vol_r      <= !show_r[D-1].vol_on ? '0 :
                        (vol_raw > marker_top) ? marker_top : vol_raw;
      out_vol_vis_r  <= show_r[D-1].vol_on;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.strip_out      = out_strip_r;
  assign out_ch.bar_px         = out_bar_r;
  assign out_ch.hold_px        = out_hold_r;
  assign out_ch.hold_visible   = out_hold_vis_r;
  assign out_ch.volume_px      = out_vol_r;
  assign out_ch.volume_visible = out_vol_vis_r;

endmodule

### src/peak_meter_ballistics_with_hold.sv
// Peak program meter with peak hold. Each transfer on in_ch carries one display
// frame's live peak (U2.14, 16384 = full scale) and volume percent for one strip;
// each produces exactly one transfer on out_ch with the bar, hold-marker and
// volume-marker heights in pixels for that strip. A front end reads the strip's
// smoothed peak, held peak and hold age from a per-strip memory, applies instant
// attack and multiplicative fall, and writes them back; it takes no new transfer
// until the last one is queued (accept with registered memory read, then update
// and queue). A 2-entry queue separates it from the back end, a 6-stage log2 ->
// dB -> pixel pipeline that converts all three values in parallel lanes at one
// item per cycle while the output is not held, followed by an output register.
// Strip state comes out of reset as zero through per-strip valid bits, so no
// clearing pass is needed. Strips at or above STRIPS leave state untouched and
// report zero heights. Configuration (cfg_addr 0: meter height, 1: fall factor,
// 2: hold fall factor, 3: hold frames) is to be written only while the block is
// idle.

module peak_meter_ballistics_with_hold #(
  parameter int STRIPS = pmbh_pkg::STRIPS_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  pmbh_in_if.sink                           in_ch,
  pmbh_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [pmbh_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [pmbh_pkg::CFG_W-1:0]        cfg_wdata
);

  pmbh_pkg::cfg_t   cfg_r;

  logic             push;
  pmbh_pkg::item_t  push_data;
  logic             full;
  logic             pop;
  pmbh_pkg::item_t  head;
  logic             empty;

  // configuration registers, plain write port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.height      <= pmbh_pkg::RST_METER_HEIGHT;
      cfg_r.fall        <= pmbh_pkg::RST_FALL;
      cfg_r.hold_fall   <= pmbh_pkg::RST_HOLD_FALL;
      cfg_r.hold_frames <= pmbh_pkg::RST_HOLD_FRAMES;
    end else if (cfg_we) begin
      unique case (pmbh_pkg::cfg_addr_t'(cfg_addr))
        pmbh_pkg::CFG_METER_HEIGHT: cfg_r.height      <= cfg_wdata[pmbh_pkg::PX_W-1:0];
        pmbh_pkg::CFG_FALL:         cfg_r.fall        <= cfg_wdata[pmbh_pkg::FACTOR_W-1:0];
        pmbh_pkg::CFG_HOLD_FALL:    cfg_r.hold_fall   <= cfg_wdata[pmbh_pkg::FACTOR_W-1:0];
        pmbh_pkg::CFG_HOLD_FRAMES:  cfg_r.hold_frames <= cfg_wdata[pmbh_pkg::AGE_W-1:0];
      endcase
    end
  end

  // front: per-strip ballistics and hold
  pmbh_front #(
    .STRIPS (STRIPS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_i       (cfg_r),
    .in_ch       (in_ch),
    .push_o      (push),
    .push_data_o (push_data),
    .full_i      (full)
  );

  // decouples the update loop from the conversion pipeline
  pmbh_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head),
    .empty_o     (empty)
  );

  // back: dB mapping to pixel heights, output register
  pmbh_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg_r),
    .head_i  (head),
    .empty_i (empty),
    .pop_o   (pop),
    .out_ch  (out_ch)
  );

endmodule

### test/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int NUM_STRIPS  = 16;
  localparam int STALL_LIMIT = 3000;  // cycles without any transfer before giving up
  localparam int SETTLE      = 16;    // lets the pipeline empty out, with some slack
  localparam int PRESSURE_AT = 150;   // result count at which the long hold-off starts
  localparam int PRESSURE_LEN = 160;

  // one frame for one strip, as offered on the input channel
  typedef struct {
    logic [pmbh_pkg::STRIP_W-1:0] strip;
    logic [pmbh_pkg::PEAK_W-1:0]  live_peak;
    logic [pmbh_pkg::VOL_W-1:0]   volume_percent;
  } meter_frame_t;

  // pixel heights for one strip, as seen on the result channel
  typedef struct {
    logic [pmbh_pkg::STRIP_W-1:0] strip;
    logic [pmbh_pkg::PX_W-1:0]    bar_px;
    logic [pmbh_pkg::PX_W-1:0]    hold_px;
    logic                         hold_visible;
    logic [pmbh_pkg::PX_W-1:0]    volume_px;
    logic                         volume_visible;
  } meter_reading_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  pmbh_pkg::cfg_addr_t          cfg_addr;
  logic [pmbh_pkg::CFG_W-1:0]   cfg_wdata;

  pmbh_in_if  in_ch();
  pmbh_out_if out_ch();

  peak_meter_ballistics_with_hold #(.STRIPS(NUM_STRIPS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Meter model: per-strip ballistics plus the log2 -> dB -> pixel mapping
  // ---------------------------------------------------------------------------
  logic [pmbh_pkg::PEAK_W-1:0]   peak_smooth [NUM_STRIPS];
  logic [pmbh_pkg::PEAK_W-1:0]   peak_held   [NUM_STRIPS];
  logic [pmbh_pkg::AGE_W-1:0]    held_age    [NUM_STRIPS];
  logic [pmbh_pkg::PX_W-1:0]     meter_h;
  logic [pmbh_pkg::FACTOR_W-1:0] smooth_fall;
  logic [pmbh_pkg::FACTOR_W-1:0] held_fall;
  logic [pmbh_pkg::AGE_W-1:0]    hold_span;

  meter_frame_t   frame_q [$];       // frames waiting for the driver
  meter_reading_t readings_due [$];  // predicted readings, oldest first
  int  frames_queued;
  int  frames_taken;
  int  readings_seen;
  int  mismatches;
  int  quiet_cycles;
  int  stall_left;
  bit  stall_done;
  bit  calm;                         // no idling on either side while set

  // log2(1 + i/16) in Q16
  function automatic int seg_log2(input int i);
    case (i)
      0: return 0;         1: return 5732;      2: return 11136;     3: return 16248;
      4: return 21098;     5: return 25711;     6: return 30109;     7: return 34312;
      8: return 38336;     9: return 42196;     10: return 45904;    11: return 49472;
      12: return 52911;    13: return 56229;    14: return 59434;    15: return 62534;
      default: return 65536;
    endcase
  endfunction

  // x > 0 read as x / 2^frac_bits, result signed Q16.16
  function automatic int log2_q16(input logic [15:0] x, input int frac_bits);
    int lead;
    int lo;
    int hi;
    logic [15:0] norm;
    lead = 0;
    for (int b = 0; b < 16; b++)
      if (x[b]) lead = b;
    norm = x << (15 - lead);
    lo = seg_log2(int'(norm[14:11]));
    hi = seg_log2(int'(norm[14:11]) + 1);
    return (lead - frac_bits) * 65536 + lo + (((hi - lo) * int'(norm[10:0])) >>> 11);
  endfunction

  // Q16.16 log2 -> Q8.8 dB, floor toward minus infinity
  function automatic int to_db_q8(input int l2);
    longint prod;
    prod = longint'(l2) * 24660;
    return int'(prod >>> 20);
  endfunction

  // -48 dB .. +6 dB onto 0 .. meter height
  function automatic int db_to_px(input int db);
    int span;
    span = db + 12288;
    if (span < 0) span = 0;
    if (span > 13824) span = 13824;
    return span * int'(meter_h) / 13824;
  endfunction

  function automatic int marker_px(input int px);
    int top;
    top = (meter_h == 0) ? 0 : int'(meter_h) - 1;
    return (px > top) ? top : px;
  endfunction

  function automatic logic [pmbh_pkg::PEAK_W-1:0] fall_off(
      input logic [pmbh_pkg::PEAK_W-1:0]   p,
      input logic [pmbh_pkg::FACTOR_W-1:0] factor);
    logic [31:0] prod;
    prod = p * factor;
    return (prod[31:16] < 17) ? '0 : prod[31:16];
  endfunction

  // advance one strip by one frame and work out the reading it should give
  task automatic advance_meter(input meter_frame_t f, output meter_reading_t r);
    logic [pmbh_pkg::PEAK_W-1:0] sp;
    logic [pmbh_pkg::PEAK_W-1:0] hp;
    int px;
    r = '{strip: f.strip, default: '0};
    if (f.strip < NUM_STRIPS) begin
      sp = (f.live_peak > peak_smooth[f.strip]) ? f.live_peak
                                                : fall_off(peak_smooth[f.strip], smooth_fall);
      peak_smooth[f.strip] = sp;

      hp = peak_held[f.strip];
      if (f.live_peak > hp) begin
        hp = f.live_peak;
        held_age[f.strip] = '0;
      end else begin
        if (held_age[f.strip] != 8'hFF) held_age[f.strip]++;
        if (held_age[f.strip] > hold_span) hp = fall_off(hp, held_fall);
      end
      peak_held[f.strip] = hp;

      if (sp > 16'd32768) sp = 16'd32768;  // bar saturates at 2.0
      if (sp >= 2) begin
        px = db_to_px(to_db_q8(log2_q16(sp, 14)));
        r.bar_px = (px > int'(meter_h)) ? meter_h : px[pmbh_pkg::PX_W-1:0];
      end
      if (hp >= 164) begin
        r.hold_visible = 1'b1;
        r.hold_px = pmbh_pkg::PX_W'(marker_px(db_to_px(to_db_q8(log2_q16(hp, 14)))));
      end
      // volume referenced to 100 percent so unity is exactly 0 dB
      if (f.volume_percent >= 2) begin
        r.volume_visible = 1'b1;
        r.volume_px = pmbh_pkg::PX_W'(marker_px(db_to_px(to_db_q8(
          log2_q16(16'(f.volume_percent), 0) - log2_q16(16'd100, 0)))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: offers frames from frame_q, predicts on each transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_frames
    meter_frame_t   cur;
    meter_frame_t   nxt;
    meter_reading_t want;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        cur = '{strip: in_ch.strip, live_peak: in_ch.live_peak,
                volume_percent: in_ch.volume_percent};
        advance_meter(cur, want);
        readings_due.push_back(want);
        frames_taken++;
      end
      if (frame_q.size() != 0 && (calm || $urandom_range(99) >= 19)) begin
        nxt = frame_q.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.strip          <= nxt.strip;
        in_ch.live_peak      <= nxt.live_peak;
        in_ch.volume_percent <= nxt.volume_percent;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: random back-pressure, one long hold-off, field checks
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch_readings
    meter_reading_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        readings_seen++;
        if (readings_due.size() == 0) begin
          $error("reading for strip %0d with nothing outstanding", out_ch.strip_out);
          mismatches++;
        end else begin
          want = readings_due.pop_front();
          check_field("strip_out", 8'(want.strip), 8'(out_ch.strip_out));
          check_field("bar_px", want.bar_px, out_ch.bar_px);
          check_field("hold_px", want.hold_px, out_ch.hold_px);
          check_field("hold_visible", 8'(want.hold_visible), 8'(out_ch.hold_visible));
          check_field("volume_px", want.volume_px, out_ch.volume_px);
          check_field("volume_visible", 8'(want.volume_visible), 8'(out_ch.volume_visible));
        end
      end
      // long hold-off once, so the block backs up and stalls in_ch
      if (stall_left != 0) begin
        stall_left--;
      end else if (!stall_done && readings_seen == PRESSURE_AT) begin
        stall_left = PRESSURE_LEN;
        stall_done = 1'b1;
      end
      out_ch.ready <= (stall_left == 0) && (calm || $urandom_range(99) >= 19);
    end
  end

  // no transfer on either side for too long means the block hung
  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic queue_frame(input int strip, input int live, input int vol);
    frame_q.push_back('{strip: strip[pmbh_pkg::STRIP_W-1:0],
                        live_peak: live[pmbh_pkg::PEAK_W-1:0],
                        volume_percent: vol[pmbh_pkg::VOL_W-1:0]});
    frames_queued++;
  endtask

  // mostly bursts on one strip: a hit, then falling or silent frames so the
  // ballistics and hold timer get exercised; the rest is scattered noise
  task automatic queue_random(input int n);
    int left;
    int strip;
    int run;
    int live;
    int vol;
    left = n;
    while (left > 0) begin
      strip = ($urandom_range(99) < 70) ? $urandom_range(3) : $urandom_range(15);
      run = ($urandom_range(99) < 15) ? 1 : $urandom_range(8, 2);
      live = $urandom_range(65535);
      vol = ($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(150);
      for (int j = 0; j < run && left > 0; j++) begin
        if (j != 0) begin
          case ($urandom_range(9))
            0, 1, 2, 3: live = 0;
            4, 5:       live = $urandom_range(live / 2);
            6:          live = $urandom_range(200);
            7:          live = $urandom_range(65535);
            default:    live = $urandom_range(live);
          endcase
          case ($urandom_range(9))
            0:       vol = $urandom_range(3);
            1:       vol = 100;
            2:       vol = 255;
            3:       vol = $urandom_range(255);
            default: ;
          endcase
        end
        queue_frame(strip, live, vol);
        left--;
      end
    end
  endtask

  // wait until every frame is taken and every reading back, then let it settle
  task automatic drain;
    while (frames_taken != frames_queued || readings_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input pmbh_pkg::cfg_addr_t addr,
                           input logic [pmbh_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (addr)
      pmbh_pkg::CFG_METER_HEIGHT: meter_h     = data[pmbh_pkg::PX_W-1:0];
      pmbh_pkg::CFG_FALL:         smooth_fall = data;
      pmbh_pkg::CFG_HOLD_FALL:    held_fall   = data;
      pmbh_pkg::CFG_HOLD_FRAMES:  hold_span   = data[pmbh_pkg::AGE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_meter(input int height, input int fall, input int hfall,
                           input int frames, input bit quiet);
    drain();
    write_reg(pmbh_pkg::CFG_METER_HEIGHT, pmbh_pkg::CFG_W'(height));
    write_reg(pmbh_pkg::CFG_FALL, pmbh_pkg::CFG_W'(fall));
    write_reg(pmbh_pkg::CFG_HOLD_FALL, pmbh_pkg::CFG_W'(hfall));
    write_reg(pmbh_pkg::CFG_HOLD_FRAMES, pmbh_pkg::CFG_W'(frames));
    calm <= quiet;
  endtask

  initial begin : stimulus
    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_addr              = pmbh_pkg::CFG_METER_HEIGHT;
    cfg_wdata             = '0;
    in_ch.valid           = 1'b0;
    in_ch.strip           = '0;
    in_ch.live_peak       = '0;
    in_ch.volume_percent  = '0;
    out_ch.ready          = 1'b0;
    calm                  = 1'b0;
    for (int i = 0; i < NUM_STRIPS; i++) begin
      peak_smooth[i] = '0;
      peak_held[i]   = '0;
      held_age[i]    = '0;
    end
    meter_h     = 8'd80;
    smooth_fall = 16'd52429;
    held_fall   = 16'd62915;
    hold_span   = 8'd30;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: edges of the fields and the thresholds
    queue_frame(0, 0, 0);            // silence, volume hidden
    queue_frame(0, 65535, 255);      // full-scale everything, bar clamped at 2.0
    queue_frame(0, 0, 100);          // first fall, unity volume is 0 dB
    queue_frame(1, 1, 1);            // below bar threshold, volume just hidden
    queue_frame(1, 2, 2);            // bar and volume thresholds
    queue_frame(2, 163, 99);         // hold marker just hidden
    queue_frame(2, 164, 101);        // hold marker just shown
    queue_frame(3, 16384, 100);      // 0 dBFS
    queue_frame(15, 32768, 200);     // last strip, peak exactly 2.0
    queue_frame(15, 32769, 50);      // just over the clamp
    queue_frame(4, 20, 10);
    queue_frame(4, 0, 10);           // fall lands under 0.001 and snaps to zero
    queue_frame(7, 43690, 170);
    queue_frame(7, 21845, 85);
    queue_random(100);

    // tallest bar, almost no fall, held peak may decay from the very next frame
    set_meter(255, 65535, 65535, 0, 1'b0);
    queue_random(60);

    // one-pixel bar, instant fall; hold expires after two frames
    set_meter(1, 0, 30000, 2, 1'b0);
    queue_frame(5, 5000, 100);
    repeat (4) queue_frame(5, 0, 100);
    queue_random(50);

    // zero height and a hold that never ends
    set_meter(0, 40000, 20000, 255, 1'b0);
    queue_random(50);

    // default ballistics, short hold, no idling on either side
    set_meter(120, 52429, 62915, 5, 1'b1);
    queue_random(80);

    // near-instant smoothed fall, held peak dropped at once after a long hold
    set_meter(200, 1, 0, 254, 1'b0);
    queue_random(80);

    drain();
    if (mismatches == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
